### src/sorted_set_insert_lookup_macros.svh
// Assertion macros used by the checker file.
`ifndef SORTED_SET_INSERT_LOOKUP_MACROS_SVH
`define SORTED_SET_INSERT_LOOKUP_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define SSET_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sset assertion failed");

// Next-cycle implication, disabled while reset is held.
`define SSET_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sset assertion failed");

`endif

### src/sset_pkg.sv
`default_nettype none

package sset_pkg;

    localparam int KEY_W        = 32;
    localparam int CNT_OUT_W    = 5;
    localparam int CAPACITY_DEF = 16;

    // Request type codes
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_LOOKUP = 1'b1;

    typedef struct packed {
        logic                    req_type;
        logic signed [KEY_W-1:0] key;
    } t_req;

    typedef struct packed {
        logic                 found;
        logic                 inserted;
        logic                 dropped_full;
        logic [CNT_OUT_W-1:0] count;
    } t_rsp;

    // Controller to datapath commands
    typedef struct packed {
        logic load_req;  // capture the accepted request
        logic do_cmp;    // register the per-entry compare results
        logic do_upd;    // shift/insert and load the result register
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CMP  = 3'b010,
        S_UPD  = 3'b100
    } t_state;

endpackage

`default_nettype wire

### src/sset_ctrl.sv
`default_nettype none

module sset_ctrl
    import sset_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_req_valid,
    output logic o_req_stall,
    output logic o_rsp_valid,
    input  wire  i_rsp_stall,
    output t_cmd o_cmd
);

    t_state r_state, n_state;
    logic   r_rsp_valid, n_rsp_valid;
    logic   out_ok;
    logic   upd;
    logic   take;

    // Result register is free or drains this cycle
    assign out_ok = !r_rsp_valid || !i_rsp_stall;
    assign upd    = (r_state == S_UPD) && out_ok;
    assign take   = (r_state == S_IDLE) || upd;

    assign o_req_stall = !take;
    assign o_rsp_valid = r_rsp_valid;

    assign o_cmd.load_req = take && i_req_valid;
    assign o_cmd.do_cmp   = (r_state == S_CMP);
    assign o_cmd.do_upd   = upd;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) n_state = S_CMP;
            end
            S_CMP: begin
                n_state = S_UPD;
            end
            S_UPD: begin
                if (out_ok) n_state = i_req_valid ? S_CMP : S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Result valid flag
    always_comb begin
        n_rsp_valid = r_rsp_valid;
        if (upd) begin
            n_rsp_valid = 1'b1;
        end else if (!i_rsp_stall) begin
            n_rsp_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rsp_valid <= n_rsp_valid;
        end
    end

endmodule

`default_nettype wire

### src/sset_dpath.sv
`default_nettype none

module sset_dpath
    import sset_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  t_cmd i_cmd,
    input  t_req i_req,
    output t_rsp o_rsp
);

    localparam int CW = $clog2(CAPACITY + 1);

    t_req                    r_req;
    logic signed [KEY_W-1:0] r_keys [CAPACITY];
    logic signed [KEY_W-1:0] n_keys [CAPACITY];
    logic [CAPACITY-1:0]     lt, eq;
    logic [CAPACITY-1:0]     r_lt, r_eq;
    logic [CW-1:0]           r_count, n_count;
    t_rsp                    r_rsp, n_rsp;
    logic                    found, full, ins, drop;

    // Accepted request
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) r_req <= i_req;
    end

    // Per-entry compare and shift cells
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic held;
        assign held  = (r_count > CW'(g));
        assign lt[g] = held && (r_keys[g] < r_req.key);
        assign eq[g] = held && (r_keys[g] == r_req.key);

        // Keep below the insert point, take the key at it, shift up above it
        if (g == 0) begin : g_first
            always_comb begin
                if (r_lt[g]) begin
                    n_keys[g] = r_keys[g];
                end else begin
                    n_keys[g] = r_req.key;
                end
            end
        end else begin : g_rest
            always_comb begin
                if (r_lt[g]) begin
                    n_keys[g] = r_keys[g];
                end else if (r_lt[g-1]) begin
                    n_keys[g] = r_req.key;
                end else begin
                    n_keys[g] = r_keys[g-1];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (ins) r_keys[g] <= n_keys[g];
        end
    end

    // Compare results
    always_ff @(posedge i_clk) begin
        if (i_cmd.do_cmp) begin
            r_lt <= lt;
            r_eq <= eq;
        end
    end

    // Outcome of the request
    assign found = |r_eq;
    assign full  = (r_count == CW'(CAPACITY));
    assign ins   = i_cmd.do_upd && (r_req.req_type == REQ_INSERT) && !found && !full;
    assign drop  = (r_req.req_type == REQ_INSERT) && !found && full;

    assign n_count = ins ? r_count + CW'(1) : r_count;

    always_comb begin
        n_rsp.found        = found;
        n_rsp.inserted     = ins;
        n_rsp.dropped_full = drop;
        n_rsp.count        = CNT_OUT_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.do_upd) r_rsp <= n_rsp;
    end

    assign o_rsp = r_rsp;

endmodule

`default_nettype wire

### src/sorted_set_insert_lookup.sv
// Each accepted request is captured, its compare results are registered in
// the compare stage over all held entries, and its result is registered in
// the shift/insert stage of the register store, which waits only while the
// previous result is still stalled at the output. A new request is taken
// only when idle or as the previous one updates. Reset: synchronous, active
// low; clears the key count and handshake state, the key store is not cleared.
`default_nettype none

module sorted_set_insert_lookup
    import sset_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_req_valid,
    output logic o_req_stall,
    input  t_req i_req,
    output logic o_rsp_valid,
    input  wire  i_rsp_stall,
    output t_rsp o_rsp
);

    t_cmd cmd;

    sset_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_stall (o_req_stall),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_stall (i_rsp_stall),
        .o_cmd       (cmd)
    );

    sset_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_req   (i_req),
        .o_rsp   (o_rsp)
    );

endmodule

`default_nettype wire

### src/sset_checker.sv
`default_nettype none

`include "sorted_set_insert_lookup_macros.svh"

module sset_checker
    import sset_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input wire  i_clk,
    input wire  i_rst_n,
    input wire  i_req_valid,
    input wire  o_req_stall,
    input wire  o_rsp_valid,
    input wire  i_rsp_stall,
    input t_rsp o_rsp
);

    logic       req_acc;
    logic       rsp_held;
    logic [2:0] rsp_flags;
    logic       count_ok;

    assign req_acc   = i_req_valid && !o_req_stall;
    assign rsp_held  = o_rsp_valid && i_rsp_stall;
    assign rsp_flags = {o_rsp.found, o_rsp.inserted, o_rsp.dropped_full};
    assign count_ok  = (CAPACITY > 31) || (int'(o_rsp.count) <= CAPACITY);

    // A stalled result holds
    `SSET_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, rsp_held, o_rsp_valid && $stable(o_rsp))

    // Compare cycle follows every accepted transaction
    `SSET_ASSERT_NEXT(a_cmp_gap, i_clk, i_rst_n, req_acc, o_req_stall)

    // At most one outcome flag per result
    `SSET_ASSERT_IMPL(a_one_flag, i_clk, i_rst_n, o_rsp_valid, $onehot0(rsp_flags))

    // Count never exceeds the capacity (checked only for capacities up to 31)
    `SSET_ASSERT_IMPL(a_count_max, i_clk, i_rst_n, o_rsp_valid, count_ok)

endmodule

bind sorted_set_insert_lookup sset_checker #(.CAPACITY(CAPACITY)) u_sset_checker (.*);

`default_nettype wire
